/* design/integer_to_decimal_ascii_core_defines.svh */
// Assertion macros shared by the integer-to-decimal ASCII core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef INTEGER_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ITDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/itda_pkg.sv */
// Shared types and constants for the integer-to-decimal ASCII core.
// No dependencies.
package itda_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned IN_W    = 64;
  localparam int unsigned OUT_W   = 8;

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  // double-dabble correction: digits of five or more get three added
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX     = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } itda_state_e;

endpackage

/* design/itda_dabble_unit.sv */
// One double-dabble step: add-3 correction on every BCD digit, then a
// one-bit left shift of the BCD and binary words. Depends on itda_pkg.
module itda_dabble_unit import itda_pkg::*; #(
  parameter int unsigned NDIG  = 20,
  parameter int unsigned BIN_W = 64
) (
  input  logic [DIGIT_W*NDIG-1:0] bcd_i,
  input  logic [BIN_W-1:0]        bin_i,
  output logic [DIGIT_W*NDIG-1:0] bcd_o,
  output logic [BIN_W-1:0]        bin_o
);

  logic [DIGIT_W*NDIG-1:0] bcd_adj;

  // per-digit correction, digits are independent
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_i[i*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // shift the binary MSB into the BCD word
  assign bcd_o = {bcd_adj[DIGIT_W*NDIG-2:0], bin_i[BIN_W-1]};
  assign bin_o = {bin_i[BIN_W-2:0], 1'b0};

endmodule

/* design/integer_to_decimal_ascii_core.sv */
// Top level of the integer-to-decimal ASCII core: sequencer, magnitude
// and BCD registers, output register. Depends on itda_pkg,
// itda_dabble_unit and integer_to_decimal_ascii_core_defines.svh.
//
//  channel  | dir | tdata                         | tlast
//  s_axis   | in  | [63:0] value (signed)         | -
//  m_axis   | out | [6:0] char_code, [7] zero pad | last character of value
//
// One item occupies the block from acceptance until its last character
// is out; a negative value adds a sign character. The cost is set by the
// shared double-dabble step (one input bit a cycle), a leading-zero skip of
// one digit a cycle and one character a cycle out while m_axis_tready holds.
// Reset (rst_ni low, asynchronous) empties the output register and
// returns the sequencer to idle. A stalled output holds its character;
// the next character waits in the sequencer.
`include "integer_to_decimal_ascii_core_defines.svh"

module integer_to_decimal_ascii_core import itda_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // [63:0] value
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // [6:0] char_code, [7] zero
  output logic             m_axis_tlast    // last
);

  localparam int unsigned NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_W = DIGIT_W * NDIG;
  localparam int unsigned CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int unsigned REM_W = $clog2(NDIG + 1);

  itda_state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic                   neg_q, neg_d;

  logic                   out_valid_q, out_valid_d;
  logic [6:0]             out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;

  logic [VALUE_WIDTH-1:0] in_raw;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [BCD_W-1:0]       dab_bcd;
  logic [VALUE_WIDTH-1:0] dab_mag;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   slot_free;

  // sign and magnitude of the incoming value
  assign in_raw = s_axis_tdata[VALUE_WIDTH-1:0];
  assign in_neg = in_raw[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (VALUE_WIDTH'(0) - in_raw) : in_raw;

  assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
  assign slot_free = !out_valid_q || m_axis_tready;

  itda_dabble_unit #(
    .NDIG  (NDIG),
    .BIN_W (VALUE_WIDTH)
  ) u_dabble (
    .bcd_i (bcd_q),
    .bin_i (mag_q),
    .bcd_o (dab_bcd),
    .bin_o (dab_mag)
  );

  // state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // sequencer: convert, skip leading zeros, sign, digits
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mag_d   = in_mag;
          neg_d   = in_neg;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_d = dab_mag;
        bcd_d = dab_bcd;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
          rem_d   = REM_W'(NDIG);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == '0 && rem_q != REM_W'(1)) begin
          bcd_d = bcd_q << DIGIT_W;
          rem_d = rem_q - 1'b1;
        end else if (neg_q) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_ZERO + {3'b000, top_digit};
          out_last_d  = (rem_q == REM_W'(1));
          bcd_d       = bcd_q << DIGIT_W;
          rem_d       = rem_q - 1'b1;
          if (rem_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;

  // checks
  `ITDA_ASSERT_NEXT(a_accept_starts_conv, s_axis_tvalid && s_axis_tready, state_q == ST_CONV, "accepted item did not start conversion")
  `ITDA_ASSERT_NOW(a_emit_digit_range, state_q == ST_EMIT, top_digit <= DIGIT_MAX, "BCD digit out of range")
  `ITDA_ASSERT_NOW(a_minus_not_last, m_axis_tvalid && (m_axis_tdata[6:0] == CHAR_MINUS), !m_axis_tlast, "minus sign marked as last character")
  `ITDA_ASSERT_NOW(a_first_digit_nonzero, state_q == ST_EMIT && $past(state_q) == ST_SKIP && rem_q != REM_W'(1), top_digit != '0, "leading zero reached output")

endmodule
